### rtl/hto_pkg.sv
// Package for the haversine track odometer: payload types, states, constants, arctangent table.
`default_nettype none
package hto_pkg;

    // CORDIC and divider iteration counts and derived widths
    localparam int CORDIC_STEPS = 24;
    localparam int DIV_STEPS    = 32;
    localparam int CNT_W        = $clog2(CORDIC_STEPS > DIV_STEPS ? CORDIC_STEPS : DIV_STEPS);
    localparam int CW           = 36;   // CORDIC datapath width, Q2.30 plus headroom

    // fixed-point constants
    localparam logic [30:0]        ONE_Q30    = 31'd1073741824;
    localparam logic [31:0]        KINV_Q30   = 32'd652032874;
    localparam logic [31:0]        PI_Q30     = 32'd3373259426;
    localparam logic signed [30:0] LAT_LIMIT  = 31'sd900000000;
    localparam logic [31:0]        DIV_HALF   = 32'd3600000000;  // half angle divisor
    localparam logic [31:0]        DIV_FULL   = 32'd1800000000;  // full angle divisor
    localparam logic [32:0]        DEG_360    = 33'd3600000000;
    localparam logic [32:0]        DEG_180    = 33'd1800000000;
    localparam logic [31:0]        MM_PER_M   = 32'd1000;
    localparam logic [65:0]        RND_Q30    = 66'd536870912;

    // configuration register indexes
    localparam logic [0:0] CFG_THRESHOLD = 1'b0;
    localparam logic [0:0] CFG_RADIUS    = 1'b1;

    // reset values of the configuration registers
    localparam logic [31:0] THRESHOLD_RST = 32'd100000;
    localparam logic [22:0] RADIUS_RST    = 23'd6371000;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
        logic               start_new_track;
    } t_in;

    typedef struct packed {
        logic [34:0] segment_mm;
        logic [47:0] total_mm;
        logic        reached;
        logic        origin_fix;
    } t_out;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_FOLD,
        ST_ALOAD,
        ST_AMUL,
        ST_ADIV,
        ST_RLOAD,
        ST_ROT,
        ST_RSTORE,
        ST_PLOAD,
        ST_PMUL,
        ST_SLOAD,
        ST_SQRT,
        ST_VLOAD,
        ST_DLOAD,
        ST_DMUL,
        ST_FIN,
        ST_DONE
    } t_state;

    // round(atan(2^-i) * 2^30)
    function automatic logic [30:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic [30:0] v;
        case (idx)
            CNT_W'(0): v = 31'd843314857;
            CNT_W'(1): v = 31'd497837829;
            CNT_W'(2): v = 31'd263043837;
            CNT_W'(3): v = 31'd133525159;
            CNT_W'(4): v = 31'd67021687;
            CNT_W'(5): v = 31'd33543516;
            CNT_W'(6): v = 31'd16775851;
            CNT_W'(7): v = 31'd8388437;
            CNT_W'(8): v = 31'd4194283;
            CNT_W'(9): v = 31'd2097149;
            default: begin
                if (idx == CNT_W'(31)) begin
                    v = 31'd1;
                end else if (idx > CNT_W'(31)) begin
                    v = 31'd0;
                end else begin
                    v = 31'd1 << (CNT_W'(30) - idx);
                end
            end
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/haversine_track_odometer.sv
// Haversine track odometer: sequencer with shared serial multiplier, divider, root and CORDIC.
//
// Usage: fixes enter on the input channel (i_in_valid / o_in_ready, payload i_in_data), one
// result per fix leaves on the output channel (o_out_valid / i_out_ready, o_out_data).
// Configuration writes use i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is the distance threshold in mm, index 1 the sphere radius in metres.
// An origin fix (restart flag, or first fix after reset) goes from ST_PREP straight to ST_DONE.
// A segment fix passes through four angle conversions (serial
// multiply by pi, 32-step restoring divide, CORDIC_STEPS rotation steps each), four
// serial products, two 31-step square roots, one vectoring CORDIC and two serial
// products for the distance in mm. The shared bit-serial multiplier and the single
// CORDIC stage serve all of these in turn; one fix is in work at a time.
// The result sits in an output register, so the next fix is accepted while it waits;
// a stalled receiver only holds the block once a second result is finished.
// Reset (synchronous, active low) clears the track, forgets the previous fix and loads
// the configuration registers with 100000 mm and 6371000 m.
`default_nettype none
module haversine_track_odometer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire hto_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output hto_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [0:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    import hto_pkg::*;

    t_state r_state, n_state;

    logic [31:0]           r_threshold, n_threshold;
    logic [22:0]           r_radius, n_radius;
    logic signed [30:0]    r_cur_lat, n_cur_lat;
    logic signed [31:0]    r_cur_lon, n_cur_lon;
    logic                  r_origin, n_origin;
    logic signed [30:0]    r_prev_lat, n_prev_lat;
    logic signed [31:0]    r_prev_lon, n_prev_lon;
    logic                  r_have_prev, n_have_prev;
    logic [47:0]           r_total, n_total;
    logic [34:0]           r_seg, n_seg;
    logic [30:0]           r_dlat, n_dlat;
    logic [32:0]           r_dlon, n_dlon;
    logic [30:0]           r_mlat1, n_mlat1;
    logic [30:0]           r_mlat2, n_mlat2;
    logic [1:0]            r_k, n_k;
    logic [1:0]            r_m, n_m;
    logic                  r_sq, n_sq;
    logic                  r_vec, n_vec;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [65:0]           r_ma, n_ma;
    logic [31:0]           r_mb, n_mb;
    logic [65:0]           r_prod, n_prod;
    logic [31:0]           r_drem, n_drem;
    logic [31:0]           r_dlo, n_dlo;
    logic signed [CW-1:0]  r_cx, n_cx;
    logic signed [CW-1:0]  r_cy, n_cy;
    logic signed [CW-1:0]  r_cz, n_cz;
    logic [30:0]           r_sl, n_sl;
    logic [30:0]           r_so, n_so;
    logic [30:0]           r_c1, n_c1;
    logic [30:0]           r_c2, n_c2;
    logic [30:0]           r_t0, n_t0;
    logic [30:0]           r_t, n_t;
    logic [30:0]           r_a, n_a;
    logic [61:0]           r_sv, n_sv;
    logic [61:0]           r_sr, n_sr;
    logic [61:0]           r_sbit, n_sbit;
    logic [30:0]           r_sa, n_sa;
    logic [30:0]           r_sb, n_sb;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    // input side latitude clamp
    logic signed [30:0]    w_lat_clamp;
    // difference magnitudes
    logic signed [31:0]    w_dlat_s;
    logic signed [32:0]    w_dlon_s;
    logic [32:0]           w_dlon_mod;
    // serial multiplier
    logic [65:0]           w_mul_sum;
    // restoring divider
    logic [31:0]           w_div;
    logic [31:0]           w_half;
    logic [63:0]           w_dvd;
    logic [32:0]           w_dt;
    logic [32:0]           w_dsub;
    logic                  w_dge;
    // CORDIC stage
    logic signed [CW-1:0]  w_xs, w_ys, w_atan;
    logic                  w_up;
    logic [CW-1:0]         w_ay, w_cxu;
    logic [30:0]           w_sabs, w_cpos;
    // products and roots
    logic [30:0]           w_pshift;
    logic [31:0]           w_asum;
    logic [30:0]           w_aclamp;
    logic [61:0]           w_strial;
    logic                  w_sge;
    logic [30:0]           w_sqin;
    logic [31:0]           w_two_z;
    logic [65:0]           w_rnd;
    logic [48:0]           w_tsum;
    logic [30:0]           w_asrc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // datapath helpers
    always_comb begin
        // latitude saturation
        if (i_in_data.latitude > LAT_LIMIT) begin
            w_lat_clamp = LAT_LIMIT;
        end else if (i_in_data.latitude < -LAT_LIMIT) begin
            w_lat_clamp = -LAT_LIMIT;
        end else begin
            w_lat_clamp = i_in_data.latitude;
        end

        w_dlat_s   = 32'(r_cur_lat) - 32'(r_prev_lat);
        w_dlon_s   = 33'(r_cur_lon) - 33'(r_prev_lon);
        w_dlon_mod = (r_dlon >= DEG_360) ? (r_dlon - DEG_360) : r_dlon;

        // one shift-add step
        w_mul_sum = r_prod + (r_mb[0] ? r_ma : 66'd0);

        // one restoring divide step by a constant divisor
        w_div  = r_k[1] ? DIV_FULL : DIV_HALF;
        w_half = {1'b0, w_div[31:1]};
        w_dvd  = r_prod[63:0] + 64'(w_half);
        w_dt   = {r_drem, r_dlo[31]};
        w_dge  = (w_dt >= {1'b0, w_div});
        w_dsub = w_dt - {1'b0, w_div};

        // one CORDIC step, rotation or vectoring
        w_xs   = r_cx >>> r_cnt;
        w_ys   = r_cy >>> r_cnt;
        w_atan = CW'(atan_q30(r_cnt));
        w_up   = r_vec ? r_cy[CW-1] : ~r_cz[CW-1];

        // clamps of CORDIC outputs
        w_ay   = r_cy[CW-1] ? CW'(-r_cy) : CW'(r_cy);
        w_cxu  = r_cx;
        w_sabs = (w_ay > CW'(ONE_Q30)) ? ONE_Q30 : w_ay[30:0];
        if (r_cx[CW-1]) begin
            w_cpos = 31'd0;
        end else if (w_cxu > CW'(ONE_Q30)) begin
            w_cpos = ONE_Q30;
        end else begin
            w_cpos = w_cxu[30:0];
        end

        // products in Q30 and the clamped haversine term
        w_pshift = r_prod[60:30];
        w_asum   = {1'b0, r_t0} + {1'b0, w_pshift};
        w_aclamp = (w_asum > 32'(ONE_Q30)) ? ONE_Q30 : w_asum[30:0];

        // one digit of the square root
        w_strial = r_sr + r_sbit;
        w_sge    = (r_sv >= w_strial);
        w_sqin   = r_sq ? (ONE_Q30 - r_a) : r_a;

        // central angle, distance rounding and saturating total
        w_two_z = r_cz[CW-1] ? 32'd0 : {r_cz[30:0], 1'b0};
        w_rnd   = r_prod + RND_Q30;
        w_tsum  = {1'b0, r_total} + 49'(r_seg);

        // angle source for the current conversion
        case (r_k)
            2'd0:    w_asrc = r_dlat;
            2'd1:    w_asrc = r_dlon[30:0];
            2'd2:    w_asrc = r_mlat1;
            default: w_asrc = r_mlat2;
        endcase
    end

    // sequencer: next state and next register values
    always_comb begin
        n_state     = r_state;
        n_threshold = r_threshold;
        n_radius    = r_radius;
        n_cur_lat   = r_cur_lat;
        n_cur_lon   = r_cur_lon;
        n_origin    = r_origin;
        n_prev_lat  = r_prev_lat;
        n_prev_lon  = r_prev_lon;
        n_have_prev = r_have_prev;
        n_total     = r_total;
        n_seg       = r_seg;
        n_dlat      = r_dlat;
        n_dlon      = r_dlon;
        n_mlat1     = r_mlat1;
        n_mlat2     = r_mlat2;
        n_k         = r_k;
        n_m         = r_m;
        n_sq        = r_sq;
        n_vec       = r_vec;
        n_cnt       = r_cnt;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_prod      = r_prod;
        n_drem      = r_drem;
        n_dlo       = r_dlo;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_sl        = r_sl;
        n_so        = r_so;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_t0        = r_t0;
        n_t         = r_t;
        n_a         = r_a;
        n_sv        = r_sv;
        n_sr        = r_sr;
        n_sbit      = r_sbit;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // configuration transfer
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: n_threshold = i_cfg_data;
                CFG_RADIUS:    n_radius    = i_cfg_data[22:0];
                default:       n_threshold = r_threshold;
            endcase
        end

        // result taken by the receiver
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cur_lat = w_lat_clamp;
                    n_cur_lon = i_in_data.longitude;
                    n_origin  = i_in_data.start_new_track || !r_have_prev;
                    n_state   = ST_PREP;
                end
            end
            ST_PREP: begin
                n_prev_lat  = r_cur_lat;
                n_prev_lon  = r_cur_lon;
                n_have_prev = 1'b1;
                n_dlat  = w_dlat_s[31] ? 31'(-w_dlat_s) : 31'(w_dlat_s);
                n_dlon  = w_dlon_s[32] ? 33'(-w_dlon_s) : 33'(w_dlon_s);
                n_mlat1 = r_prev_lat[30] ? 31'(-r_prev_lat) : 31'(r_prev_lat);
                n_mlat2 = r_cur_lat[30] ? 31'(-r_cur_lat) : 31'(r_cur_lat);
                if (r_origin) begin
                    n_seg   = 35'd0;
                    n_total = 48'd0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                // wrap the longitude difference into 0..180 degrees
                n_dlon  = (w_dlon_mod > DEG_180) ? (DEG_360 - w_dlon_mod) : w_dlon_mod;
                n_k     = 2'd0;
                n_state = ST_ALOAD;
            end
            ST_ALOAD: begin
                n_ma    = 66'(w_asrc);
                n_mb    = PI_Q30;
                n_prod  = 66'd0;
                n_state = ST_AMUL;
            end
            ST_AMUL: begin
                if (r_mb == 32'd0) begin
                    n_drem  = w_dvd[63:32];
                    n_dlo   = w_dvd[31:0];
                    n_cnt   = '0;
                    n_state = ST_ADIV;
                end else begin
                    n_prod = w_mul_sum;
                    n_ma   = {r_ma[64:0], 1'b0};
                    n_mb   = {1'b0, r_mb[31:1]};
                end
            end
            ST_ADIV: begin
                n_drem = w_dge ? w_dsub[31:0] : w_dt[31:0];
                n_dlo  = {r_dlo[30:0], w_dge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_RLOAD;
                end
            end
            ST_RLOAD: begin
                n_cx    = CW'(KINV_Q30);
                n_cy    = '0;
                n_cz    = CW'(r_dlo);
                n_cnt   = '0;
                n_vec   = 1'b0;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                if (w_up) begin
                    n_cx = r_cx - w_ys;
                    n_cy = r_cy + w_xs;
                    n_cz = r_cz - w_atan;
                end else begin
                    n_cx = r_cx + w_ys;
                    n_cy = r_cy - w_xs;
                    n_cz = r_cz + w_atan;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    if (r_vec) begin
                        n_m     = 2'd0;
                        n_state = ST_DLOAD;
                    end else begin
                        n_state = ST_RSTORE;
                    end
                end
            end
            ST_RSTORE: begin
                case (r_k)
                    2'd0:    n_sl = w_sabs;
                    2'd1:    n_so = w_sabs;
                    2'd2:    n_c1 = w_cpos;
                    default: n_c2 = w_cpos;
                endcase
                if (r_k == 2'd3) begin
                    n_m     = 2'd0;
                    n_state = ST_PLOAD;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_ALOAD;
                end
            end
            ST_PLOAD: begin
                case (r_m)
                    2'd0: begin
                        n_ma = 66'(r_sl);
                        n_mb = 32'(r_sl);
                    end
                    2'd1: begin
                        n_ma = 66'(r_so);
                        n_mb = 32'(r_so);
                    end
                    2'd2: begin
                        n_ma = 66'(r_t);
                        n_mb = 32'(r_c1);
                    end
                    default: begin
                        n_ma = 66'(r_t);
                        n_mb = 32'(r_c2);
                    end
                endcase
                n_prod  = 66'd0;
                n_state = ST_PMUL;
            end
            ST_PMUL: begin
                if (r_mb == 32'd0) begin
                    case (r_m)
                        2'd0:    n_t0 = w_pshift;
                        2'd3:    n_a  = w_aclamp;
                        default: n_t  = w_pshift;
                    endcase
                    if (r_m == 2'd3) begin
                        n_sq    = 1'b0;
                        n_state = ST_SLOAD;
                    end else begin
                        n_m     = r_m + 2'd1;
                        n_state = ST_PLOAD;
                    end
                end else begin
                    n_prod = w_mul_sum;
                    n_ma   = {r_ma[64:0], 1'b0};
                    n_mb   = {1'b0, r_mb[31:1]};
                end
            end
            ST_SLOAD: begin
                n_sv    = 62'({w_sqin, 30'd0});
                n_sr    = 62'd0;
                n_sbit  = 62'd1 << 60;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_sbit == 62'd0) begin
                    if (r_sq) begin
                        n_sb    = r_sr[30:0];
                        n_state = ST_VLOAD;
                    end else begin
                        n_sa    = r_sr[30:0];
                        n_sq    = 1'b1;
                        n_state = ST_SLOAD;
                    end
                end else begin
                    if (w_sge) begin
                        n_sv = r_sv - w_strial;
                        n_sr = {1'b0, r_sr[61:1]} + r_sbit;
                    end else begin
                        n_sr = {1'b0, r_sr[61:1]};
                    end
                    n_sbit = {2'b00, r_sbit[61:2]};
                end
            end
            ST_VLOAD: begin
                n_cx    = CW'(r_sb);
                n_cy    = CW'(r_sa);
                n_cz    = '0;
                n_cnt   = '0;
                n_vec   = 1'b1;
                n_state = ST_ROT;
            end
            ST_DLOAD: begin
                if (!r_m[0]) begin
                    n_ma = 66'(r_radius);
                    n_mb = w_two_z;
                end else begin
                    n_ma = r_prod;
                    n_mb = MM_PER_M;
                end
                n_prod  = 66'd0;
                n_state = ST_DMUL;
            end
            ST_DMUL: begin
                if (r_mb == 32'd0) begin
                    if (!r_m[0]) begin
                        n_m     = 2'd1;
                        n_state = ST_DLOAD;
                    end else begin
                        n_seg   = w_rnd[64:30];
                        n_state = ST_FIN;
                    end
                end else begin
                    n_prod = w_mul_sum;
                    n_ma   = {r_ma[64:0], 1'b0};
                    n_mb   = {1'b0, r_mb[31:1]};
                end
            end
            ST_FIN: begin
                n_total = w_tsum[48] ? '1 : w_tsum[47:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.segment_mm = r_seg;
                    n_out.total_mm   = r_total;
                    n_out.reached    = (r_total >= 48'(r_threshold));
                    n_out.origin_fix = r_origin;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_radius    <= RADIUS_RST;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
            r_have_prev <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_threshold <= n_threshold;
            r_radius    <= n_radius;
            r_prev_lat  <= n_prev_lat;
            r_prev_lon  <= n_prev_lon;
            r_have_prev <= n_have_prev;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cur_lat <= n_cur_lat;
        r_cur_lon <= n_cur_lon;
        r_origin  <= n_origin;
        r_seg     <= n_seg;
        r_dlat    <= n_dlat;
        r_dlon    <= n_dlon;
        r_mlat1   <= n_mlat1;
        r_mlat2   <= n_mlat2;
        r_k       <= n_k;
        r_m       <= n_m;
        r_sq      <= n_sq;
        r_vec     <= n_vec;
        r_cnt     <= n_cnt;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_prod    <= n_prod;
        r_drem    <= n_drem;
        r_dlo     <= n_dlo;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_cz      <= n_cz;
        r_sl      <= n_sl;
        r_so      <= n_so;
        r_c1      <= n_c1;
        r_c2      <= n_c2;
        r_t0      <= n_t0;
        r_t       <= n_t;
        r_a       <= n_a;
        r_sv      <= n_sv;
        r_sr      <= n_sr;
        r_sbit    <= n_sbit;
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_out     <= n_out;
    end

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the haversine track odometer: directed fixes, random tracks.
module testbench;
    import hto_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    haversine_track_odometer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    localparam longint unsigned TRACK_MAX = (64'd1 << 48) - 1;
    localparam longint          ONE_Q     = 64'sd1073741824;

    // predictor copy of state and registers
    longint unsigned thr_mm;
    longint unsigned radius_m;
    longint          last_lat;
    longint          last_lon;
    bit              have_last;
    longint unsigned odo_total;

    t_out fix_results[$];
    int   errors;
    int   fixes_sent;
    int   results_seen;
    int   origins_seen;
    int   reached_seen;
    bit   stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30000000;
        $display("FAIL haversine_track_odometer");
        $finish;
    end

    task automatic report(input string what, input longint unsigned exp_v,
                          input longint unsigned got_v);
        errors++;
        $display("mismatch %s: expected %0d got %0d (result %0d)", what, exp_v, got_v,
                 results_seen);
    endtask

    // round(atan(2^-i) * 2^30) from the alternating series in Q62
    function automatic longint atan_entry(input int i);
        longint sum;
        longint unsigned term;
        int k;
        int sh;
        sum = 0;
        if (i == 0) return 64'sd843314857;
        for (k = 0; ; k++) begin
            sh = 62 - i * (2 * k + 1);
            if (sh < 0) break;
            term = (64'd1 << sh) / longint'(2 * k + 1);
            if (k & 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return (sum + (64'sd1 << 31)) >>> 32;
    endfunction

    task automatic rotate(input longint theta, output longint cx, output longint sy);
        longint x, y, z, nx;
        x = 64'sd652032874;
        y = 0;
        z = theta;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_entry(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_entry(i);
            end
            x = nx;
        end
        cx = x;
        sy = y;
    endtask

    function automatic longint vector_angle(input longint x0, input longint y0);
        longint x, y, z, nx;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_entry(i);
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_entry(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v0);
        longint unsigned v, r, b;
        v = v0;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned absval(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned unit_clamp(input longint v);
        longint unsigned m;
        m = absval(v);
        return m > ONE_Q ? ONE_Q : m;
    endfunction

    // great-circle distance in mm between two fixes
    task automatic arc_mm(input longint lat1, input longint lon1, input longint lat2,
                          input longint lon2, output longint unsigned mm);
        longint unsigned dlat, dlon, sl, so, c1, c2, a, sa, sb, q;
        longint hlat, hlon, r1, r2, cc, ss, c1v, c2v, z;
        dlat = absval(lat2 - lat1);
        dlon = absval(lon2 - lon1) % 64'd3600000000;
        if (dlon > 64'd1800000000) dlon = 64'd3600000000 - dlon;
        hlat = (dlat * 64'd3373259426 + 64'd1800000000) / 64'd3600000000;
        hlon = (dlon * 64'd3373259426 + 64'd1800000000) / 64'd3600000000;
        r1 = (absval(lat1) * 64'd3373259426 + 64'd900000000) / 64'd1800000000;
        r2 = (absval(lat2) * 64'd3373259426 + 64'd900000000) / 64'd1800000000;
        rotate(hlat, cc, ss);
        sl = unit_clamp(ss);
        rotate(hlon, cc, ss);
        so = unit_clamp(ss);
        rotate(r1, c1v, ss);
        rotate(r2, c2v, ss);
        c1 = c1v < 0 ? 0 : unit_clamp(c1v);
        c2 = c2v < 0 ? 0 : unit_clamp(c2v);
        a = ((sl * sl) >> 30) + ((((((so * so) >> 30) * c1) >> 30) * c2) >> 30);
        if (a > ONE_Q) a = ONE_Q;
        sa = int_root(a << 30);
        sb = int_root((ONE_Q - a) << 30);
        z = vector_angle(sb, sa);
        if (z < 0) z = 0;
        q = radius_m * longint'(2 * z);
        mm = (q >> 30) * 1000 + ((((q & ((64'd1 << 30) - 1)) * 1000) + (64'd1 << 29)) >> 30);
    endtask

    // advance the odometer model by one fix
    task automatic odometer_step(input t_in f, output t_out r);
        longint lat, lon;
        longint unsigned seg;
        bit origin;
        lat = longint'(f.latitude);
        lon = longint'(f.longitude);
        origin = f.start_new_track || !have_last;
        seg = 0;
        if (lat > 900000000) lat = 900000000;
        if (lat < -900000000) lat = -900000000;
        if (origin) begin
            odo_total = 0;
        end else begin
            arc_mm(last_lat, last_lon, lat, lon, seg);
            if (seg > TRACK_MAX - odo_total) odo_total = TRACK_MAX;
            else odo_total += seg;
        end
        last_lat  = lat;
        last_lon  = lon;
        have_last = 1'b1;
        r.segment_mm = seg[34:0];
        r.total_mm   = odo_total[47:0];
        r.reached    = odo_total >= thr_mm;
        r.origin_fix = origin;
    endtask

    // offer one fix; returns at the transfer edge with valid still high
    task automatic offer_fix(input t_in f, input bit typed, input t_out typed_res);
        t_out r;
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (!o_in_ready);
        odometer_step(f, r);
        if (typed) r = typed_res;
        fix_results.push_back(r);
        fixes_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (fix_results.size() != 0);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_THRESHOLD) thr_mm = val;
        else radius_m = val[22:0];
    endtask

    // receiver stall pattern: stretches of free flow and of random stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        if (stall_mode) i_out_ready <= ($urandom_range(0, 2) == 0);
        else i_out_ready <= 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (fix_results.size() == 0) begin
                report("unexpected result", 0, 1);
            end else begin
                e = fix_results.pop_front();
                if (o_out_data.segment_mm !== e.segment_mm)
                    report("segment_mm", e.segment_mm, o_out_data.segment_mm);
                if (o_out_data.total_mm !== e.total_mm)
                    report("total_mm", e.total_mm, o_out_data.total_mm);
                if (o_out_data.reached !== e.reached)
                    report("reached", e.reached, o_out_data.reached);
                if (o_out_data.origin_fix !== e.origin_fix)
                    report("origin_fix", e.origin_fix, o_out_data.origin_fix);
                if (e.origin_fix) origins_seen++;
                if (e.reached) reached_seen++;
            end
            results_seen++;
        end
    end

    // directed fixes: lat, lon, restart, typed origin result
    localparam int NDIR = 20;
    longint dir_lat [NDIR] = '{0, 0, 900000000, -900000000, 1073741823, -1073741824,
                               0, 0, 0, 0, 123456789, 123456789, 0, 0, 450000000,
                               -450000000, 10, 899999999, 0, 0};
    longint dir_lon [NDIR] = '{0, 0, 0, 0, 0, 0, 1800000000, -1800000000, 2147483647,
                               -2147483648, 0, 0, 0, 1800000000, 1, 1, 20, 0, 0, 0};
    bit     dir_new [NDIR] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0};

    task automatic random_fix(output t_in f);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7 && have_last) begin
            // nearby fix continuing the track
            f.latitude  = 31'(last_lat + longint'($urandom_range(0, 200000)) - 100000);
            f.longitude = 32'(last_lon + longint'($urandom_range(0, 200000)) - 100000);
        end else if (kind < 9) begin
            f.latitude  = 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
            f.longitude = 32'(longint'($urandom_range(0, 2147483647)) * 2 - 1800000000);
        end else begin
            f.latitude  = 31'($urandom);
            f.longitude = $urandom;
        end
        f.start_new_track = ($urandom_range(0, 14) == 0);
    endtask

    initial begin
        t_in  f;
        t_out tr;
        int   burst;
        int   gap;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_THRESHOLD;
        i_cfg_data  = '0;
        stall_mode  = 1'b0;
        errors = 0; fixes_sent = 0; results_seen = 0; origins_seen = 0; reached_seen = 0;
        thr_mm = THRESHOLD_RST; radius_m = RADIUS_RST;
        last_lat = 0; last_lon = 0; have_last = 1'b0; odo_total = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < NDIR; i++) begin
            f.latitude        = 31'(dir_lat[i]);
            f.longitude       = 32'(dir_lon[i]);
            f.start_new_track = dir_new[i];
            tr = '{segment_mm: '0, total_mm: '0, reached: 1'b0, origin_fix: 1'b1};
            offer_fix(f, (i == 0) || dir_new[i], tr);
            if ($urandom_range(0, 2) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end

        // random tracks over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin write_reg(CFG_THRESHOLD, 32'd0);          write_reg(CFG_RADIUS, 32'd6300000); end
                2: begin write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);  write_reg(CFG_RADIUS, 32'd6400000); end
                3: begin write_reg(CFG_THRESHOLD, $urandom_range(0, 50000000));
                         write_reg(CFG_RADIUS, 32'd0); end
                4: begin write_reg(CFG_THRESHOLD, $urandom);       write_reg(CFG_RADIUS, 32'h7F_FFFF); end
                5: begin write_reg(CFG_THRESHOLD, 32'd100000);     write_reg(CFG_RADIUS, 32'd6371000); end
                default: ;
            endcase
            burst = 0;
            for (int n = 0; n < 72; n++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 10);
                    gap   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                random_fix(f);
                offer_fix(f, 1'b0, tr);
                burst--;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("fixes sent %0d, results checked %0d, origin fixes %0d, threshold hits %0d",
                 fixes_sent, results_seen, origins_seen, reached_seen);
        $display("register phases 6, radius and threshold extremes included");
        if (errors == 0 && fix_results.size() == 0) begin
            $display("PASS haversine_track_odometer");
        end else begin
            if (fix_results.size() != 0)
                report("results never arrived", 0, fix_results.size());
            $display("FAIL haversine_track_odometer");
        end
        $finish;
    end
endmodule
